[rtl/fvmc_pkg.sv]
// Shared types, constants and tables for the five-bar leg torque mapping block.
package fvmc_pkg;

    // configuration register indexes
    localparam logic CFG_UPPER = 1'b0;
    localparam logic CFG_LOWER = 1'b1;

    localparam logic [15:0] BAR_LEN_RESET = 16'd9830;

    // default number of rotation steps in each trig unit
    localparam int TRIG_ITER_DEF = 16;

    // datapath widths
    localparam int ANG_W  = 36;   // wrapped angle, Q28
    localparam int Z_W    = 32;   // residual angle inside the rotator
    localparam int XY_W   = 34;   // rotator x and y, Q30
    localparam int TRIG_W = 18;   // sin and cos, Q16
    localparam int NUM_W  = 53;   // Jacobian numerator
    localparam int DEN_W  = 35;   // Jacobian denominator
    localparam int DIV_W  = 66;   // divider remainder
    localparam int DIV_QB = 31;   // quotient bits below the saturation limit

    // angle constants in Q28
    localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd843314857;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd421657428;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [31:0] J_LIMIT = 32'sd2147483647;

    // atan(2^-i) in Q28
    localparam logic [31:0] ATAN_Q28 [0:23] = '{
        32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290,
        32'd16755422,  32'd8385879,   32'd4193963,  32'd2097109,
        32'd1048571,   32'd524287,    32'd262144,   32'd131072,
        32'd65536,     32'd32768,     32'd16384,    32'd8192,
        32'd4096,      32'd2048,      32'd1024,     32'd512,
        32'd256,       32'd128,       32'd64,       32'd32
    };

    typedef struct packed {
        logic signed [15:0] leg_angle;
        logic signed [15:0] joint_angle_one;
        logic signed [15:0] joint_angle_two;
        logic signed [15:0] joint_angle_three;
        logic signed [15:0] joint_angle_four;
        logic [15:0]        leg_length;
        logic signed [31:0] hip_torque_cmd;
        logic signed [31:0] leg_force_cmd;
    } t_item;

    typedef struct packed {
        logic signed [31:0] front_joint_torque;
        logic signed [31:0] rear_joint_torque;
        logic               singular;
    } t_result;

endpackage

[rtl/fvmc_cordic.sv]
// Pipelined rotation-mode CORDIC: one Q28 angle in, rounded Q16 sin and cos out.
module fvmc_cordic
    import fvmc_pkg::*;
#(
    parameter int ITER = TRIG_ITER_DEF
) (
    input  logic                     i_clk,
    input  logic signed [ANG_W-1:0]  i_ang,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    logic signed [XY_W-1:0] r_x   [0:ITER];
    logic signed [XY_W-1:0] r_y   [0:ITER];
    logic signed [Z_W-1:0]  r_z   [0:ITER];
    logic                   r_neg [0:ITER];

    logic signed [XY_W-1:0] w_xf, w_yf, w_xr, w_yr;

    // fold into [-pi/2, pi/2], remembering the sign flip
    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        if (i_ang > ANG_HALF_PI) begin
            r_z[0]   <= Z_W'(i_ang - ANG_PI);
            r_neg[0] <= 1'b1;
        end else if (i_ang < -ANG_HALF_PI) begin
            r_z[0]   <= Z_W'(i_ang + ANG_PI);
            r_neg[0] <= 1'b1;
        end else begin
            r_z[0]   <= Z_W'(i_ang);
            r_neg[0] <= 1'b0;
        end
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < ITER; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            r_neg[k+1] <= r_neg[k];
            if (!r_z[k][Z_W-1]) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - Z_W'(ATAN_Q28[k]);
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + Z_W'(ATAN_Q28[k]);
            end
        end
    end

    // undo the fold and round Q30 to Q16
    always_comb begin
        w_xf = r_neg[ITER] ? -r_x[ITER] : r_x[ITER];
        w_yf = r_neg[ITER] ? -r_y[ITER] : r_y[ITER];
        w_xr = (w_xf + XY_W'(8192)) >>> 14;
        w_yr = (w_yf + XY_W'(8192)) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        o_sin <= w_yr[TRIG_W-1:0];
        o_cos <= w_xr[TRIG_W-1:0];
    end

endmodule

[rtl/fvmc_div.sv]
// Pipelined signed divider, rounded to nearest and saturated to a Q16.16 word.
module fvmc_div
    import fvmc_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic signed [31:0]      o_quo
);

    logic [NUM_W-1:0] r_un;
    logic [DEN_W-1:0] r_ud;
    logic             r_sneg;

    logic [DIV_W-1:0]  r_rem [0:DIV_QB];
    logic [DEN_W-1:0]  r_dv  [0:DIV_QB];
    logic [DIV_QB-1:0] r_q   [0:DIV_QB];
    logic              r_ovf [0:DIV_QB];
    logic              r_neg [0:DIV_QB];

    logic [DIV_W-1:0]  w_sum;
    logic [DIV_QB-1:0] w_qs;

    // magnitudes and result sign
    always_ff @(posedge i_clk) begin
        r_un   <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        r_ud   <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        r_sneg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
    end

    // add half the divisor for rounding; check quotient against the limit
    assign w_sum = DIV_W'(r_un) + DIV_W'(r_ud >> 1);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_sum;
        r_dv[0]  <= r_ud;
        r_q[0]   <= '0;
        r_ovf[0] <= w_sum >= (DIV_W'(r_ud) << DIV_QB);
        r_neg[0] <= r_sneg;
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar s = 0; s < DIV_QB; s++) begin : g_bit
        localparam int B = DIV_QB - 1 - s;
        logic [DIV_W-1:0] w_sh;
        assign w_sh = DIV_W'(r_dv[s]) << B;
        always_ff @(posedge i_clk) begin
            r_dv[s+1]  <= r_dv[s];
            r_ovf[s+1] <= r_ovf[s];
            r_neg[s+1] <= r_neg[s];
            if (r_rem[s] >= w_sh) begin
                r_rem[s+1] <= r_rem[s] - w_sh;
                r_q[s+1]   <= r_q[s] | (DIV_QB'(1) << B);
            end else begin
                r_rem[s+1] <= r_rem[s];
                r_q[s+1]   <= r_q[s];
            end
        end
    end

    // saturate and apply sign
    assign w_qs = r_ovf[DIV_QB] ? J_LIMIT[DIV_QB-1:0] : r_q[DIV_QB];

    always_ff @(posedge i_clk) begin
        o_quo <= r_neg[DIV_QB] ? -$signed({1'b0, w_qs}) : $signed({1'b0, w_qs});
    end

endmodule

[rtl/five_bar_leg_vmc_torque.sv]
// Five-bar leg virtual-model torque mapping: Jacobian by CORDIC, divide and MAC.
// Throughput: one word per cycle; busy stays low, the receiver cannot stall, order is kept.
// The depth is set by the rotation stages of the trig units and the 31-bit divider.
// Reset (synchronous, active low) clears the valid pipeline and reloads both bar lengths.
module five_bar_leg_vmc_torque
    import fvmc_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output t_result     o_result
);

    localparam int LAT_TRIG = TRIG_ITERATIONS + 2;
    localparam int LAT_DIV  = DIV_QB + 3;
    localparam int LAT_ALL  = LAT_TRIG + LAT_DIV + 5;

    localparam logic signed [ANG_W-1:0] ANG_PI3 = ANG_PI + ANG_TWO_PI;
    localparam logic signed [ANG_W-1:0] ANG_PI5 = ANG_PI + ANG_TWO_PI + ANG_TWO_PI;

    typedef struct packed {
        logic [15:0]        l0;
        logic signed [31:0] tp;
        logic signed [31:0] f;
    } t_tside;

    typedef struct packed {
        logic signed [31:0] tp;
        logic signed [31:0] f;
        logic               sing;
    } t_dside;

    // multiple of two pi to take off
    function automatic logic signed [ANG_W-1:0] two_pi_times(input logic [1:0] k);
        logic signed [ANG_W-1:0] v;
        unique case (k)
            2'd0:    v = '0;
            2'd1:    v = ANG_TWO_PI;
            2'd2:    v = ANG_TWO_PI + ANG_TWO_PI;
            default: v = ANG_TWO_PI + ANG_TWO_PI + ANG_TWO_PI;
        endcase
        return v;
    endfunction

    // difference of two Q3.12 angles, moved to Q28 and wrapped into [-pi, pi]
    function automatic logic signed [ANG_W-1:0] wrap_diff(input logic signed [15:0] a,
                                                          input logic signed [15:0] b);
        logic signed [16:0]      d;
        logic signed [ANG_W-1:0] r;
        logic [1:0]              kp, kn;
        d  = {a[15], a} - {b[15], b};
        r  = {{3{d[16]}}, d, 16'b0};
        kp = 2'(r > ANG_PI) + 2'(r > ANG_PI3) + 2'(r > ANG_PI5);
        kn = 2'(r < -ANG_PI) + 2'(r < -ANG_PI3) + 2'(r < -ANG_PI5);
        return r - two_pi_times(kp) + two_pi_times(kn);
    endfunction

    // 32-bit saturation of a rounded Q32.32 sum
    function automatic logic signed [31:0] sat_torque(input logic signed [64:0] s);
        logic signed [64:0] t;
        t = (s + 65'sd32768) >>> 16;
        if (t > 65'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (t < -65'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return t[31:0];
        end
    endfunction

    logic [15:0] r_l1, r_l4;
    logic [LAT_ALL-1:0] r_vld;

    logic signed [ANG_W-1:0]  r_ang [0:4];
    logic signed [TRIG_W-1:0] w_sin [0:4];
    logic signed [TRIG_W-1:0] w_cos [0:4];
    t_tside                   r_tside [0:LAT_TRIG];

    logic signed [35:0]      r_p [0:3];
    logic signed [DEN_W-1:0] r_d0, r_d1;
    t_dside                  r_m1;

    logic signed [NUM_W-1:0] r_n [0:3];
    logic signed [DEN_W-1:0] r_dn0, r_dn1;
    t_dside                  r_dside [0:LAT_DIV];

    logic signed [31:0] w_j [0:3];
    logic signed [63:0] r_pa1, r_pb1, r_pa2, r_pb2;
    logic               r_tm_sing;
    t_result            r_out;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= BAR_LEN_RESET;
            r_l4 <= BAR_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UPPER: r_l1 <= i_cfg_data;
                CFG_LOWER: r_l4 <= i_cfg_data;
            endcase
        end
    end

    // valid bits alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT_ALL-2:0], start & ~busy};
        end
    end

    // angle differences: q3-q2, q1-q2, q0-q3, q3-q4, q0-q2
    always_ff @(posedge i_clk) begin
        r_ang[0]   <= wrap_diff(i_item.joint_angle_three, i_item.joint_angle_two);
        r_ang[1]   <= wrap_diff(i_item.joint_angle_one, i_item.joint_angle_two);
        r_ang[2]   <= wrap_diff(i_item.leg_angle, i_item.joint_angle_three);
        r_ang[3]   <= wrap_diff(i_item.joint_angle_three, i_item.joint_angle_four);
        r_ang[4]   <= wrap_diff(i_item.leg_angle, i_item.joint_angle_two);
        r_tside[0] <= '{l0: i_item.leg_length, tp: i_item.hip_torque_cmd,
                        f: i_item.leg_force_cmd};
    end

    for (genvar a = 0; a < 5; a++) begin : g_trig
        fvmc_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic (
            .i_clk (i_clk),
            .i_ang (r_ang[a]),
            .o_sin (w_sin[a]),
            .o_cos (w_cos[a])
        );
    end

    // side payload waits for the trig units
    for (genvar k = 1; k <= LAT_TRIG; k++) begin : g_tside
        always_ff @(posedge i_clk) begin
            r_tside[k] <= r_tside[k-1];
        end
    end

    // first products: sin*cos and sin*sin terms and denominators
    always_ff @(posedge i_clk) begin
        r_p[0]  <= w_sin[1] * w_cos[2];
        r_p[1]  <= w_sin[1] * w_sin[2];
        r_p[2]  <= w_sin[3] * w_cos[4];
        r_p[3]  <= w_sin[3] * w_sin[4];
        r_d0    <= $signed({1'b0, r_tside[LAT_TRIG].l0}) * w_sin[0];
        r_d1    <= {w_sin[0][TRIG_W-1], w_sin[0], 16'b0};
        r_m1.tp <= r_tside[LAT_TRIG].tp;
        r_m1.f  <= r_tside[LAT_TRIG].f;
        r_m1.sing <= (w_sin[0] == '0) || (r_tside[LAT_TRIG].l0 == '0);
    end

    // numerators: bar length times the sin*cos and sin*sin products
    always_ff @(posedge i_clk) begin
        r_n[0]     <= $signed({1'b0, r_l1}) * r_p[0];
        r_n[1]     <= $signed({1'b0, r_l1}) * r_p[1];
        r_n[2]     <= $signed({1'b0, r_l4}) * r_p[2];
        r_n[3]     <= $signed({1'b0, r_l4}) * r_p[3];
        r_dn0      <= r_d0;
        r_dn1      <= r_d1;
        r_dside[0] <= r_m1;
    end

    fvmc_div u_div0 (.i_clk(i_clk), .i_num(r_n[0]), .i_den(r_dn0), .o_quo(w_j[0]));
    fvmc_div u_div1 (.i_clk(i_clk), .i_num(r_n[1]), .i_den(r_dn1), .o_quo(w_j[1]));
    fvmc_div u_div2 (.i_clk(i_clk), .i_num(r_n[2]), .i_den(r_dn0), .o_quo(w_j[2]));
    fvmc_div u_div3 (.i_clk(i_clk), .i_num(r_n[3]), .i_den(r_dn1), .o_quo(w_j[3]));

    for (genvar k = 1; k <= LAT_DIV; k++) begin : g_dside
        always_ff @(posedge i_clk) begin
            r_dside[k] <= r_dside[k-1];
        end
    end

    // Jacobian times commands
    always_ff @(posedge i_clk) begin
        r_pa1     <= w_j[0] * r_dside[LAT_DIV].tp;
        r_pb1     <= w_j[1] * r_dside[LAT_DIV].f;
        r_pa2     <= w_j[2] * r_dside[LAT_DIV].tp;
        r_pb2     <= w_j[3] * r_dside[LAT_DIV].f;
        r_tm_sing <= r_dside[LAT_DIV].sing;
    end

    // sum, round, saturate; singular geometry forces zero
    always_ff @(posedge i_clk) begin
        r_out.singular <= r_tm_sing;
        if (r_tm_sing) begin
            r_out.front_joint_torque <= '0;
            r_out.rear_joint_torque  <= '0;
        end else begin
            r_out.front_joint_torque <= sat_torque(65'(r_pa1) + 65'(r_pb1));
            r_out.rear_joint_torque  <= sat_torque(65'(r_pa2) + 65'(r_pb2));
        end
    end

    assign o_strobe = r_vld[LAT_ALL-1];
    assign o_result = r_out;

`ifndef ASSERT_OFF
    // a singular word carries zero torques
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.singular |->
            o_result.front_joint_torque == '0 && o_result.rear_joint_torque == '0)
        else $error("singular word with nonzero torque");

    // every word out matches a word taken in through start while not busy
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT_ALL))
        else $error("result word without matching start");

    // zero commands give zero torques
    a_zero_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(start && i_item.hip_torque_cmd == '0 &&
                          i_item.leg_force_cmd == '0, LAT_ALL) |->
            o_result.front_joint_torque == '0 && o_result.rear_joint_torque == '0)
        else $error("nonzero torque from zero commands");
`endif

endmodule
